// ===== sv/hsv_to_rgb_converter_defines.svh =====
// assertion macros shared by the hsv to rgb converter
`ifndef HSV_TO_RGB_CONVERTER_DEFINES_SVH
`define HSV_TO_RGB_CONVERTER_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define HSV_ASSERT_NOW(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define HSV_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== sv/hsv2rgb_pkg.sv =====
// shared constants, stage types and a helper function of the hsv to rgb converter
package hsv2rgb_pkg;

  localparam int unsigned HueMax       = 359;
  localparam int unsigned DegPerSector = 60;
  localparam int unsigned FracOne      = 255;

  // x = s*v*t / (255*60), done as a reciprocal multiply plus one correction
  localparam int unsigned XDiv   = FracOne * DegPerSector;
  localparam int unsigned XShift = 30;
  localparam logic [16:0] X_RECIP = 17'((64'd1 << XShift) / XDiv);
  localparam logic [21:0] X_DIV   = 22'(XDiv);

  localparam logic [8:0] HUE_MAX = 9'(HueMax);

  typedef enum logic [2:0] {
    SEC_RED_YEL = 3'd0,
    SEC_YEL_GRN = 3'd1,
    SEC_GRN_CYN = 3'd2,
    SEC_CYN_BLU = 3'd3,
    SEC_BLU_MAG = 3'd4,
    SEC_MAG_RED = 3'd5
  } sector_e;

  // after hue decode and the two 8x8 products
  typedef struct packed {
    logic        vld;
    sector_e     sector;
    logic [5:0]  ramp;
    logic [15:0] sv;
    logic [15:0] vn;
  } s1_t;

  // chroma and offset scaled, secondary product formed
  typedef struct packed {
    logic        vld;
    sector_e     sector;
    logic [21:0] svt;
    logic [7:0]  ci;
    logic [7:0]  mi;
  } s2_t;

  // secondary quotient estimate
  typedef struct packed {
    logic        vld;
    sector_e     sector;
    logic [21:0] svt;
    logic [7:0]  qx;
    logic [7:0]  ci;
    logic [7:0]  mi;
  } s3_t;

  // all three components final
  typedef struct packed {
    logic       vld;
    sector_e    sector;
    logic [7:0] ci;
    logic [7:0] xi;
    logic [7:0] mi;
  } s4_t;

  // floor(x / 255) for x up to 255*255: shift-add estimate, one correction
  function automatic logic [7:0] div255(input logic [15:0] x);
    logic [16:0] sum;
    logic [16:0] q0;
    logic [16:0] rem;
    sum = {1'b0, x} + {9'd0, x[15:8]};
    q0  = {8'd0, sum[16:8]};
    rem = {1'b0, x} - ((q0 << 8) - q0);
    if (rem >= 17'(FracOne)) begin
      q0 = q0 + 17'd1;
    end
    return q0[7:0];
  endfunction

endpackage

// ===== sv/hsv2rgb_front.sv =====
// first stage: hue clamp, sector and ramp decode, chroma and offset products
module hsv2rgb_front import hsv2rgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  logic       vld_i,
  input  logic [8:0] hue_deg_i,
  input  logic [7:0] sat_frac_i,
  input  logic [7:0] val_frac_i,
  output s1_t        s1_o
);

  logic [8:0] hue_c;
  logic [8:0] base;
  logic [5:0] off;
  sector_e    sector;
  s1_t        s1_d, s1_q;

  always_comb begin
    hue_c = (hue_deg_i > HUE_MAX) ? HUE_MAX : hue_deg_i;
    if (hue_c < 9'd60) begin
      sector = SEC_RED_YEL;
    end else if (hue_c < 9'd120) begin
      sector = SEC_YEL_GRN;
    end else if (hue_c < 9'd180) begin
      sector = SEC_GRN_CYN;
    end else if (hue_c < 9'd240) begin
      sector = SEC_CYN_BLU;
    end else if (hue_c < 9'd300) begin
      sector = SEC_BLU_MAG;
    end else begin
      sector = SEC_MAG_RED;
    end
    case (sector)
      SEC_RED_YEL: base = 9'd0;
      SEC_YEL_GRN: base = 9'd60;
      SEC_GRN_CYN: base = 9'd120;
      SEC_CYN_BLU: base = 9'd180;
      SEC_BLU_MAG: base = 9'd240;
      default:     base = 9'd300;
    endcase
    off = 6'(hue_c - base);

    s1_d.vld    = vld_i;
    s1_d.sector = sector;
    // falling half of the triangle in odd sectors
    s1_d.ramp   = sector[0] ? (6'(DegPerSector) - off) : off;
    s1_d.sv     = {8'd0, sat_frac_i} * {8'd0, val_frac_i};
    s1_d.vn     = {8'd0, val_frac_i} * {8'd0, 8'(FracOne) - sat_frac_i};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_q <= '0;
    end else if (adv_i) begin
      s1_q <= s1_d;
    end
  end

  assign s1_o = s1_q;

endmodule

// ===== sv/hsv2rgb_scale.sv =====
// stages two to four: scaling of chroma, offset and secondary component
module hsv2rgb_scale import hsv2rgb_pkg::*; (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic adv_i,
  input  s1_t  s1_i,
  output s4_t  s4_o
);

  s2_t s2_d, s2_q;
  s3_t s3_d, s3_q;
  s4_t s4_d, s4_q;

  logic [38:0] qx_prod;
  logic [21:0] qx_back;
  logic [21:0] x_rem;

  always_comb begin
    s2_d.vld    = s1_i.vld;
    s2_d.sector = s1_i.sector;
    s2_d.svt    = {6'd0, s1_i.sv} * {16'd0, s1_i.ramp};
    s2_d.ci     = div255(s1_i.sv);
    s2_d.mi     = div255(s1_i.vn);
  end

  always_comb begin
    qx_prod     = {17'd0, s2_q.svt} * {22'd0, X_RECIP};
    s3_d.vld    = s2_q.vld;
    s3_d.sector = s2_q.sector;
    s3_d.svt    = s2_q.svt;
    // estimate never exceeds the true quotient, so it fits eight bits
    s3_d.qx     = qx_prod[XShift +: 8];
    s3_d.ci     = s2_q.ci;
    s3_d.mi     = s2_q.mi;
  end

  always_comb begin
    qx_back     = {14'd0, s3_q.qx} * X_DIV;
    x_rem       = s3_q.svt - qx_back;
    s4_d.vld    = s3_q.vld;
    s4_d.sector = s3_q.sector;
    s4_d.xi     = (x_rem >= X_DIV) ? (s3_q.qx + 8'd1) : s3_q.qx;
    s4_d.ci     = s3_q.ci;
    s4_d.mi     = s3_q.mi;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_q <= '0;
      s3_q <= '0;
      s4_q <= '0;
    end else if (adv_i) begin
      s2_q <= s2_d;
      s3_q <= s3_d;
      s4_q <= s4_d;
    end
  end

  assign s4_o = s4_q;

endmodule

// ===== sv/hsv2rgb_mix.sv =====
// last stage: sector ordering, offset add and output register
module hsv2rgb_mix import hsv2rgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       adv_i,
  input  s4_t        s4_i,
  output logic       vld_o,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

  logic [7:0] rr, gg, bb;
  logic       vld_q;
  logic [7:0] red_q, green_q, blue_q;

  always_comb begin
    case (s4_i.sector)
      SEC_RED_YEL: begin rr = s4_i.ci; gg = s4_i.xi; bb = 8'd0;    end
      SEC_YEL_GRN: begin rr = s4_i.xi; gg = s4_i.ci; bb = 8'd0;    end
      SEC_GRN_CYN: begin rr = 8'd0;    gg = s4_i.ci; bb = s4_i.xi; end
      SEC_CYN_BLU: begin rr = 8'd0;    gg = s4_i.xi; bb = s4_i.ci; end
      SEC_BLU_MAG: begin rr = s4_i.xi; gg = 8'd0;    bb = s4_i.ci; end
      default:     begin rr = s4_i.ci; gg = 8'd0;    bb = s4_i.xi; end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
    end else if (adv_i) begin
      vld_q <= s4_i.vld;
    end
  end

  // ci + mi never exceeds v, so the sums stay in eight bits
  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      red_q   <= rr + s4_i.mi;
      green_q <= gg + s4_i.mi;
      blue_q  <= bb + s4_i.mi;
    end
  end

  assign vld_o   = vld_q;
  assign red_o   = red_q;
  assign green_o = green_q;
  assign blue_o  = blue_q;

endmodule

// ===== sv/hsv_to_rgb_converter.sv =====
// top level of the hsv to rgb converter: five-stage pipeline and its assertions
// Converts one HSV pixel per clock cycle to 8-bit RGB; an accepted input transaction
// passes through all five registered stages to its output transaction. Hue is in
// whole degrees, values above 359 are treated as 359; saturation and value are
// fractions of 255. The pipeline runs as one lockstep chain: stage one decodes the
// hue sector and triangle ramp and forms s*v and v*(255-s), stage two scales chroma
// and offset by 1/255 and forms s*v*ramp, stages three and four divide that product
// by 255*60 through a reciprocal multiply and a single remainder correction, and
// stage five orders the components by sector and adds the offset. The chain moves
// whenever the output register is empty or being taken, so throughput is one
// transaction per cycle as long as the downstream side does not stall; in_stall_o
// is high exactly while a finished pixel waits at the output and out_stall_i holds
// it. The block has no state beyond the pipeline and needs no setup after reset.
module hsv_to_rgb_converter import hsv2rgb_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid_i,
  output logic       in_stall_o,
  input  logic [8:0] hue_deg_i,
  input  logic [7:0] sat_frac_i,
  input  logic [7:0] val_frac_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] red_o,
  output logic [7:0] green_o,
  output logic [7:0] blue_o
);

`include "hsv_to_rgb_converter_defines.svh"

  // whole pipeline advances together; bubbles travel with their valid bit cleared
  logic adv;
  s1_t  s1;
  s4_t  s4;

  assign adv        = !out_valid_o || !out_stall_i;
  assign in_stall_o = !adv;

  hsv2rgb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .adv_i      (adv),
    .vld_i      (in_valid_i),
    .hue_deg_i  (hue_deg_i),
    .sat_frac_i (sat_frac_i),
    .val_frac_i (val_frac_i),
    .s1_o       (s1)
  );

  hsv2rgb_scale u_scale (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .adv_i  (adv),
    .s1_i   (s1),
    .s4_o   (s4)
  );

  hsv2rgb_mix u_mix (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .s4_i    (s4),
    .vld_o   (out_valid_o),
    .red_o   (red_o),
    .green_o (green_o),
    .blue_o  (blue_o)
  );

  // an accepted input transaction always lands in the first stage
  `HSV_ASSERT_NEXT(a_accept_lands, in_valid_i && !in_stall_o, s1.vld, "accepted pixel lost")

  // input side only stalls behind a held output
  `HSV_ASSERT_NOW(a_stall_cause, in_stall_o, out_valid_o && out_stall_i, "stall without cause")

  // the secondary component never exceeds the chroma
  `HSV_ASSERT_NOW(a_x_le_c, s4.vld, s4.xi <= s4.ci, "secondary above chroma")

endmodule
